FILE: rtl/chns_pkg.sv
// Shared types and constants for the channel-hopping noise survey unit.
// Used by the top level, the serial divider and the checker.
// No dependencies.
package chns_pkg;

   localparam int NUM_CHANNELS_DEF = 16;

   // Configuration port.
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_TARGET = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DWELL_FRAMES = 4'd1;

   localparam logic [23:0] FRAME_TARGET_RST = 24'd3600;
   localparam logic [15:0] DWELL_FRAMES_RST = 16'd60;
   localparam logic [23:0] FRAMES_MAX       = 24'hFF_FFFF;
   localparam logic [15:0] DWELL_MAX        = 16'hFFFF;
   localparam logic [6:0]  PCT_FULL         = 7'd100;

   // Command codes.
   localparam logic [2:0] OP_BLOCK = 3'd0;
   localparam logic [2:0] OP_TICK  = 3'd1;
   localparam logic [2:0] OP_START = 3'd2;
   localparam logic [2:0] OP_STOP  = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   // Scan modes.
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_SCAN = 2'd1;
   localparam logic [1:0] MODE_DONE = 2'd2;

   // Serial divider geometry.
   localparam int DIV_N_W   = 40;
   localparam int DIV_D_W   = 32;
   localparam int DIV_STEPS = DIV_N_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

   // One channel's statistics as held in the store.
   typedef struct packed {
      logic [39:0] sum;
      logic [31:0] samples;
      logic [7:0]  avg;
      logic [7:0]  peak;
   } entry_type;

endpackage

FILE: rtl/chns_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the per-channel statistics. No dependencies.
module chns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/chns_div.sv
// Restoring serial divider, one quotient bit per cycle, 40-bit dividend by
// 32-bit divisor. Depends on chns_pkg for the request and response types.
module chns_div (
   input  logic                 clock,
   input  logic                 reset,
   input  chns_pkg::div_req_type req,
   output chns_pkg::div_rsp_type rsp
);
   import chns_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   dvs_ff, dvs_in;

   logic [DIV_D_W:0] rem_sh;
   logic [DIV_D_W:0] diff;
   logic             ge;

   assign rem_sh = {rem_ff, quo_ff[DIV_N_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign ge     = (rem_sh >= {1'b0, dvs_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = req.dividend;
         rem_in   = '0;
         dvs_in   = req.divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DIV_N_W-2:0], ge};
         rem_in   = ge ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

FILE: rtl/channel_hop_noise_stats_unit.sv
// Top level of the channel-hopping noise survey unit: sequencer, scan state,
// configuration registers and result registers.
// Depends on chns_pkg, chns_div and chns_ram.

// An item is taken when start is high and busy is low. Busy then stays high
// until the result has been formed. The result appears for exactly one cycle
// with rsp_valid high, so the receiver must take it then. Busy falls at the
// edge where rsp_valid rises, so the next item can be taken at the edge that
// ends the result cycle. All divisions go through one restoring divider that
// yields one quotient bit per cycle. An rssi block with a nonzero count
// during a scan divides three times (block mean, channel average, progress);
// the channel average division is skipped when the channel's sample count is
// full. Every other item divides only for the progress. With a zero frame
// target the progress division is skipped. The channel store is cleared at
// once by per-channel valid bits, so there is no clearing pass after reset or
// after a clear command.
module channel_hop_noise_stats_unit #(
   parameter int NUM_CHANNELS = chns_pkg::NUM_CHANNELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [2:0]                         req_op,
   input  logic [31:0]                        req_stat_accumulator,
   input  logic [15:0]                        req_stat_count,
   output logic                               rsp_valid,
   output logic [3:0]                         rsp_channel_index,
   output logic [1:0]                         rsp_scan_mode,
   output logic [7:0]                         rsp_last_mean,
   output logic [7:0]                         rsp_channel_average,
   output logic [7:0]                         rsp_channel_peak,
   output logic [6:0]                         rsp_progress_percent,
   output logic                               rsp_hopped,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [chns_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [chns_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import chns_pkg::*;

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_MEAN   = 3'd2;
   localparam logic [2:0] S_AVG    = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_PROG   = 3'd5;
   localparam logic [2:0] S_PWAIT  = 3'd6;

   // Control state.
   logic [2:0]              state_ff, state_in;
   logic [1:0]              mode_ff, mode_in;
   logic [23:0]             frames_ff, frames_in;
   logic [15:0]             dwell_ff, dwell_in;
   logic [CH_W-1:0]         ch_ff, ch_in;
   logic [7:0]              recent_ff, recent_in;
   logic [NUM_CHANNELS-1:0] valid_ff, valid_in;
   logic [23:0]             frame_target_ff, frame_target_in;
   logic [15:0]             dwell_frames_ff, dwell_frames_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Item and work registers.
   logic [2:0]  op_ff, op_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        hop_ff, hop_in;
   logic [39:0] sum_ff, sum_in;
   logic [31:0] samp_ff, samp_in;
   logic [7:0]  max_ff, max_in;
   logic        rd_valid_ff;

   // Result registers.
   logic [3:0] rsp_channel_index_ff, rsp_channel_index_in;
   logic [1:0] rsp_scan_mode_ff, rsp_scan_mode_in;
   logic [7:0] rsp_last_mean_ff, rsp_last_mean_in;
   logic [7:0] rsp_channel_average_ff, rsp_channel_average_in;
   logic [7:0] rsp_channel_peak_ff, rsp_channel_peak_in;
   logic [6:0] rsp_progress_percent_ff, rsp_progress_percent_in;
   logic       rsp_hopped_ff, rsp_hopped_in;

   // Channel store and divider.
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic               ram_we;
   entry_type          ram_wdata;
   logic [$bits(entry_type)-1:0] ram_rdata;
   entry_type          entry;

   logic [23:0]     frames_inc;
   logic [15:0]     dwell_inc;
   logic [7:0]      mean;
   logic [7:0]      peak_new;
   logic [39:0]     sum_new;
   logic [31:0]     samp_new;
   logic [30:0]     frames_x100;
   logic [CH_W+3:0] ch_ext;
   logic [6:0]      pct_sat;

   chns_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // The store is always read at the current channel; writes go there too.
   chns_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (NUM_CHANNELS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ch_ff),
      .wdata (ram_wdata),
      .raddr (ch_ff),
      .rdata (ram_rdata)
   );

   // An entry not written since reset or the last clear reads as zero.
   assign entry = rd_valid_ff ? entry_type'(ram_rdata) : '0;

   assign frames_inc  = (frames_ff < FRAMES_MAX) ? frames_ff + 24'd1 : frames_ff;
   assign dwell_inc   = (dwell_ff < DWELL_MAX) ? dwell_ff + 16'd1 : dwell_ff;
   assign mean        = div_rsp.quotient[7:0];
   assign peak_new    = (mean > entry.peak) ? mean : entry.peak;
   assign sum_new     = entry.sum + {32'd0, mean};
   assign samp_new    = entry.samples + 32'd1;
   assign frames_x100 = {1'b0, frames_ff, 6'd0} + {2'b0, frames_ff, 5'd0}
                      + {5'b0, frames_ff, 2'd0};
   assign ch_ext      = {4'd0, ch_ff};
   assign pct_sat     = (div_rsp.quotient > 40'd100) ? PCT_FULL
                                                     : div_rsp.quotient[6:0];

   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      frames_in       = frames_ff;
      dwell_in        = dwell_ff;
      ch_in           = ch_ff;
      recent_in       = recent_ff;
      valid_in        = valid_ff;
      frame_target_in = frame_target_ff;
      dwell_frames_in = dwell_frames_ff;
      rsp_valid_in    = 1'b0;
      op_in           = op_ff;
      acc_in          = acc_ff;
      cnt_in          = cnt_ff;
      hop_in          = hop_ff;
      sum_in          = sum_ff;
      samp_in         = samp_ff;
      max_in          = max_ff;
      rsp_channel_index_in    = rsp_channel_index_ff;
      rsp_scan_mode_in        = rsp_scan_mode_ff;
      rsp_last_mean_in        = rsp_last_mean_ff;
      rsp_channel_average_in  = rsp_channel_average_ff;
      rsp_channel_peak_in     = rsp_channel_peak_ff;
      rsp_progress_percent_in = rsp_progress_percent_ff;
      rsp_hopped_in           = rsp_hopped_ff;
      div_req          = '0;
      ram_we           = 1'b0;
      ram_wdata        = entry;

      if (csr_valid) begin
         if (csr_index == REG_FRAME_TARGET) begin
            frame_target_in = csr_wdata[23:0];
         end else if (csr_index == REG_DWELL_FRAMES) begin
            dwell_frames_in = csr_wdata[15:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_op;
               acc_in   = req_stat_accumulator;
               cnt_in   = req_stat_count;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            hop_in   = 1'b0;
            state_in = S_READ;
            case (op_ff)
               OP_BLOCK: begin
                  if (mode_ff == MODE_SCAN && cnt_ff != 16'd0) begin
                     div_req.start    = 1'b1;
                     div_req.dividend = {8'd0, acc_ff};
                     div_req.divisor  = {16'd0, cnt_ff};
                     state_in         = S_MEAN;
                  end
               end
               OP_TICK: begin
                  if (mode_ff == MODE_SCAN) begin
                     frames_in = frames_inc;
                     if (frames_inc >= frame_target_ff) begin
                        mode_in = MODE_DONE;
                     end else if (dwell_inc >= dwell_frames_ff) begin
                        ch_in    = (ch_ff == CH_W'(NUM_CHANNELS - 1))
                                 ? '0 : ch_ff + 1'b1;
                        dwell_in = '0;
                        hop_in   = 1'b1;
                     end else begin
                        dwell_in = dwell_inc;
                     end
                  end
               end
               OP_START: begin
                  if (mode_ff != MODE_SCAN) begin
                     frames_in = '0;
                     dwell_in  = '0;
                     ch_in     = '0;
                     mode_in   = MODE_SCAN;
                  end
               end
               OP_STOP: begin
                  if (mode_ff == MODE_SCAN) begin
                     mode_in = MODE_IDLE;
                  end
               end
               OP_CLEAR: begin
                  if (mode_ff == MODE_SCAN) begin
                     mode_in = MODE_IDLE;
                  end
                  valid_in  = '0;
                  frames_in = '0;
                  dwell_in  = '0;
                  ch_in     = '0;
                  recent_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_MEAN: begin
            if (div_rsp.done) begin
               recent_in = mean;
               max_in    = peak_new;
               if (entry.samples != '1) begin
                  sum_in           = sum_new;
                  samp_in          = samp_new;
                  div_req.start    = 1'b1;
                  div_req.dividend = sum_new;
                  div_req.divisor  = samp_new;
                  state_in         = S_AVG;
               end else begin
                  // A full sample count freezes sum and average; only the peak moves.
                  ram_we         = 1'b1;
                  ram_wdata.peak = peak_new;
                  valid_in[ch_ff] = 1'b1;
                  state_in       = S_READ;
               end
            end
         end
         S_AVG: begin
            if (div_rsp.done) begin
               ram_we            = 1'b1;
               ram_wdata.sum     = sum_ff;
               ram_wdata.samples = samp_ff;
               ram_wdata.avg     = div_rsp.quotient[7:0];
               ram_wdata.peak    = max_ff;
               valid_in[ch_ff]   = 1'b1;
               state_in          = S_READ;
            end
         end
         S_READ: begin
            // The store read of the final channel lands at the end of this cycle.
            state_in = S_PROG;
         end
         S_PROG: begin
            rsp_channel_average_in = entry.avg;
            rsp_channel_peak_in    = entry.peak;
            rsp_channel_index_in   = ch_ext[3:0];
            rsp_scan_mode_in       = mode_ff;
            rsp_last_mean_in       = recent_ff;
            rsp_hopped_in          = hop_ff;
            if (frame_target_ff == 24'd0) begin
               rsp_progress_percent_in = (frames_ff != 24'd0) ? PCT_FULL : 7'd0;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {9'd0, frames_x100};
               div_req.divisor  = {8'd0, frame_target_ff};
               state_in         = S_PWAIT;
            end
         end
         S_PWAIT: begin
            if (div_rsp.done) begin
               rsp_progress_percent_in = pct_sat;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         mode_ff         <= MODE_IDLE;
         frames_ff       <= '0;
         dwell_ff        <= '0;
         ch_ff           <= '0;
         recent_ff       <= '0;
         valid_ff        <= '0;
         frame_target_ff <= FRAME_TARGET_RST;
         dwell_frames_ff <= DWELL_FRAMES_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         mode_ff         <= mode_in;
         frames_ff       <= frames_in;
         dwell_ff        <= dwell_in;
         ch_ff           <= ch_in;
         recent_ff       <= recent_in;
         valid_ff        <= valid_in;
         frame_target_ff <= frame_target_in;
         dwell_frames_ff <= dwell_frames_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      hop_ff      <= hop_in;
      sum_ff      <= sum_in;
      samp_ff     <= samp_in;
      max_ff      <= max_in;
      rd_valid_ff <= valid_ff[ch_ff];
      rsp_channel_index_ff    <= rsp_channel_index_in;
      rsp_scan_mode_ff        <= rsp_scan_mode_in;
      rsp_last_mean_ff        <= rsp_last_mean_in;
      rsp_channel_average_ff  <= rsp_channel_average_in;
      rsp_channel_peak_ff     <= rsp_channel_peak_in;
      rsp_progress_percent_ff <= rsp_progress_percent_in;
      rsp_hopped_ff           <= rsp_hopped_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_channel_index    = rsp_channel_index_ff;
   assign rsp_scan_mode        = rsp_scan_mode_ff;
   assign rsp_last_mean        = rsp_last_mean_ff;
   assign rsp_channel_average  = rsp_channel_average_ff;
   assign rsp_channel_peak     = rsp_channel_peak_ff;
   assign rsp_progress_percent = rsp_progress_percent_ff;
   assign rsp_hopped           = rsp_hopped_ff;

endmodule

FILE: rtl/chns_checker.sv
// Port-level checks for the channel-hopping noise survey unit, bound to the
// top level. Depends on chns_pkg and channel_hop_noise_stats_unit.
module chns_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_scan_mode,
   input logic [6:0] rsp_progress_percent,
   input logic       rsp_hopped
);
   import chns_pkg::*;

   // An accepted item keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   // Each item gives a single one-cycle result.
   a_single_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_progress_percent <= PCT_FULL))
      else $error("progress above full scale");

   // A hop only happens on a tick that leaves the scan running.
   a_hop_scanning: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hopped) |-> (rsp_scan_mode == MODE_SCAN))
      else $error("hop reported outside a running scan");

endmodule

bind channel_hop_noise_stats_unit chns_checker u_chns_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .rsp_valid            (rsp_valid),
   .rsp_scan_mode        (rsp_scan_mode),
   .rsp_progress_percent (rsp_progress_percent),
   .rsp_hopped           (rsp_hopped)
);
